FILE: rtl/pfd_pkg.sv
// shared types and constants for the frame deframer
// no dependencies; imported by every module of the block
`default_nettype none

package pfd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [BYTE_W-1:0] START_RESET = 8'd20;
  localparam logic [BYTE_W-1:0] DEST_RESET  = 8'h0c;
  localparam logic [BYTE_W-1:0] SRC_RESET   = 8'h00;
  localparam logic [LEN_W-1:0]  MAX_RESET   = 16'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE = 2'd0,
    REG_DEST       = 2'd1,
    REG_SRC        = 2'd2,
    REG_MAX_PAYLOAD = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_DEST   = 3'd1,
    PH_SRC    = 3'd2,
    PH_TYPE   = 3'd3,
    PH_LEN_HI = 3'd4,
    PH_LEN_LO = 3'd5,
    PH_BODY   = 3'd6
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    EV_PAYLOAD = 2'd0,
    EV_EMPTY   = 2'd1,
    EV_HEADER  = 2'd2,
    EV_OVERRUN = 2'd3
  } event_kind_t;

  typedef struct packed {
    event_kind_t       kind;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] msg_type;
    logic [LEN_W-1:0]  index;
    logic              last;
  } event_t;

endpackage

`default_nettype wire

FILE: rtl/pfd_front.sv
// front end: configuration registers and the byte-wise frame parser
// depends on pfd_pkg; emits at most one event word per accepted byte
`default_nettype none

module pfd_front (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_write,
  input  wire [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [pfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                          accept,
  input  wire [pfd_pkg::BYTE_W-1:0]    rx_data,
  output logic                         ev_valid,
  output pfd_pkg::event_t              ev
);
  import pfd_pkg::*;

  logic [BYTE_W-1:0]  start_byte;
  logic [BYTE_W-1:0]  exp_dest;
  logic [BYTE_W-1:0]  exp_src;
  logic [LEN_W-1:0]   max_payload;

  phase_t             phase;
  phase_t             phase_next;
  logic [BYTE_W-1:0]  held_type;
  logic [LEN_W-1:0]   held_length;
  logic [COUNT_W-1:0] received_count;
  logic [COUNT_W-1:0] count_inc;
  logic [LEN_W-1:0]   length_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte  <= START_RESET;
      exp_dest    <= DEST_RESET;
      exp_src     <= SRC_RESET;
      max_payload <= MAX_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_BYTE:  start_byte  <= cfg_data[BYTE_W-1:0];
        REG_DEST:        exp_dest    <= cfg_data[BYTE_W-1:0];
        REG_SRC:         exp_src     <= cfg_data[BYTE_W-1:0];
        REG_MAX_PAYLOAD: max_payload <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
    end else begin
      phase <= phase_next;
    end
  end

  assign count_inc   = received_count + 1'b1;
  assign length_full = {held_length[LEN_W-1:BYTE_W], rx_data};

  always_comb begin
    phase_next   = phase;
    ev_valid     = 1'b0;
    ev.kind      = EV_PAYLOAD;
    ev.data      = rx_data;
    ev.msg_type  = held_type;
    ev.index     = received_count[LEN_W-1:0];
    ev.last      = 1'b0;
    if (accept) begin
      case (phase)
        PH_HUNT: begin
          if (rx_data == start_byte) phase_next = PH_DEST;
        end
        PH_DEST, PH_SRC: begin
          if (rx_data != ((phase == PH_DEST) ? exp_dest : exp_src)) begin
            phase_next  = PH_HUNT;
            ev_valid    = 1'b1;
            ev.kind     = EV_HEADER;
            ev.msg_type = '0;
            ev.index    = '0;
          end else begin
            phase_next = (phase == PH_DEST) ? PH_SRC : PH_TYPE;
          end
        end
        PH_TYPE:   phase_next = PH_LEN_HI;
        PH_LEN_HI: phase_next = PH_LEN_LO;
        PH_LEN_LO: begin
          if (length_full == '0) begin
            phase_next = PH_HUNT;
            ev_valid   = 1'b1;
            ev.kind    = EV_EMPTY;
            ev.index   = '0;
            ev.last    = 1'b1;
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          ev_valid = 1'b1;
          if (count_inc > {1'b0, max_payload}) begin
            phase_next = PH_HUNT;
            ev.kind    = EV_OVERRUN;
          end else if (count_inc == {1'b0, held_length}) begin
            phase_next = PH_HUNT;
            ev.last    = 1'b1;
          end
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_type      <= '0;
      held_length    <= '0;
      received_count <= '0;
    end else if (accept) begin
      case (phase)
        PH_TYPE:   held_type   <= rx_data;
        PH_LEN_HI: held_length <= {rx_data, {BYTE_W{1'b0}}};
        PH_LEN_LO: begin
          held_length    <= length_full;
          received_count <= '0;
        end
        PH_BODY:   received_count <= count_inc;
        default: ;
      endcase
    end
  end

  // inside a frame body the count always fits in sixteen bits
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> !received_count[COUNT_W-1])
    else $error("payload count ran past the largest frame length");

endmodule

`default_nettype wire

FILE: rtl/pfd_queue.sv
// short event queue between the parser and the output stage
// depends on pfd_pkg for the event word
`default_nettype none

module pfd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              wr_en,
  input  wire pfd_pkg::event_t wr_data,
  input  wire              rd_en,
  output pfd_pkg::event_t  rd_data,
  output logic             q_full,
  output logic             q_empty
);
  import pfd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  event_t          slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign q_full  = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue fill count above depth");

  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !q_full)
    else $error("event written into a full queue");

  assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a write");

endmodule

`default_nettype wire

FILE: rtl/pfd_back.sv
// back end: registered result stage refilled from the event queue
// depends on pfd_pkg for the event word
`default_nettype none

module pfd_back (
  input  wire              clk,
  input  wire              rst,
  input  wire              q_empty,
  input  wire pfd_pkg::event_t q_data,
  output logic             q_pop,
  input  wire              pop,
  output logic             out_valid,
  output pfd_pkg::event_t  out_data
);
  import pfd_pkg::*;

  // refill when the slot is free or being taken this cycle
  assign q_pop = !q_empty && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_data <= q_data;
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> out_valid && out_data == $past(out_data))
    else $error("waiting result changed before it was taken");

endmodule

`default_nettype wire

FILE: rtl/phonet_frame_deframer_unit.sv
// frame deframer: one received byte per cycle while full is low, at most one result word each
// a result word is written into the event queue, then loaded into the registered output stage
// throughput: one byte per cycle while full is low, set by the parser's per-byte phase update
// full rises only when the event queue between parser and output stage fills
// reset (synchronous, rst high): registers to defaults, parser hunting, queue empty
// depends on pfd_pkg, pfd_front, pfd_queue, pfd_back
`default_nettype none

module phonet_frame_deframer_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_write,
  input  wire [pfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [pfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                            push,
  output logic                           full,
  input  wire [pfd_pkg::BYTE_W-1:0]      rx_data,
  output logic                           empty,
  input  wire                            pop,
  output logic [pfd_pkg::KIND_W-1:0]     event_kind,
  output logic [pfd_pkg::BYTE_W-1:0]     payload_byte,
  output logic [pfd_pkg::BYTE_W-1:0]     message_kind,
  output logic [pfd_pkg::LEN_W-1:0]      byte_index,
  output logic                           frame_end
);
  import pfd_pkg::*;

  logic   accept;
  logic   ev_valid;
  event_t ev;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  event_t q_data;
  logic   out_valid;
  event_t out_data;

  assign accept = push && !q_full;
  assign full   = q_full;
  assign empty  = !out_valid;

  pfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_data   (rx_data),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  pfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ev_valid),
    .wr_data (ev),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  pfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign event_kind   = out_data.kind;
  assign payload_byte = out_data.data;
  assign message_kind = out_data.msg_type;
  assign byte_index   = out_data.index;
  assign frame_end    = out_data.last;

endmodule

`default_nettype wire
